[rtl/box_overlap_pair_event_tracker_defines.svh]
// Assertion macros shared by the box overlap pair event tracker RTL.
// Assertions compile away when SYNTHESIS is defined; no other dependencies.
`ifndef BOX_OVERLAP_PAIR_EVENT_TRACKER_DEFINES_SVH
`define BOX_OVERLAP_PAIR_EVENT_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define BOPT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bopt assertion failed");
`define BOPT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("bopt forbidden condition seen");
`else
`define BOPT_ASSERT(label, clk, rst_n, prop)
`define BOPT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/bopt_pkg.sv]
// Package for the box overlap pair event tracker: field widths, beat layouts,
// event codes and parameter defaults. No dependencies.
`default_nettype none

package bopt_pkg;

	localparam int ID_W = 6;
	localparam int CENTER_W = 16;
	localparam int SIZE_W = 15;
	localparam int ID_COUNT_DEF = 64;
	localparam int COORD_BITS_DEF = 16;

	localparam int IN_BITS = 2 * ID_W + 4 * CENTER_W + 4 * SIZE_W + 2;
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8;
	localparam int EV_W = 2;
	localparam int OUT_BITS = EV_W + 2 * ID_W;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [EV_W-1:0] {
		EV_NONE  = 2'd0,
		EV_ENTER = 2'd1,
		EV_STAY  = 2'd2,
		EV_EXIT  = 2'd3
	} bopt_event_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} bopt_adv_t;

endpackage

`default_nettype wire

[rtl/bopt_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module bopt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/bopt_overlap.sv]
// Two-stage box overlap test: center differences and size sums, then the strict compare.
// Depends on bopt_pkg.
`default_nettype none

module bopt_overlap #(
	parameter int COORD_BITS = bopt_pkg::COORD_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bopt_pkg::bopt_adv_t             adv,
	input  wire logic [bopt_pkg::CENTER_W-1:0]   a_center_x,
	input  wire logic [bopt_pkg::CENTER_W-1:0]   a_center_y,
	input  wire logic [bopt_pkg::SIZE_W-1:0]     a_width,
	input  wire logic [bopt_pkg::SIZE_W-1:0]     a_height,
	input  wire logic [bopt_pkg::CENTER_W-1:0]   b_center_x,
	input  wire logic [bopt_pkg::CENTER_W-1:0]   b_center_y,
	input  wire logic [bopt_pkg::SIZE_W-1:0]     b_width,
	input  wire logic [bopt_pkg::SIZE_W-1:0]     b_height,
	output logic                                 hit_s2
);

	import bopt_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int SUM_W = SIZE_W + 1;
	localparam int SW = ((CW + 2 > SUM_W + 1) ? CW + 2 : SUM_W + 1) + 1;

	function automatic logic signed [CW-1:0] coord(input logic [CENTER_W-1:0] raw);
		logic [CW+CENTER_W-1:0] ext;
		ext = {{CW{1'b0}}, raw};
		return signed'(ext[CW-1:0]);
	endfunction

	logic signed [CW-1:0] cax, cay, cbx, cby;
	logic signed [CW:0]   dx_s1, dy_s1;
	logic [SUM_W-1:0]     sumx_s1, sumy_s1;
	logic signed [SW-1:0] twox, twoy, sx, sy;
	logic                 hit;

	assign cax = coord(a_center_x);
	assign cay = coord(a_center_y);
	assign cbx = coord(b_center_x);
	assign cby = coord(b_center_y);

	always_ff @(posedge clk) begin
		if (adv.ld_s1) begin
			dx_s1   <= signed'({cax[CW-1], cax}) - signed'({cbx[CW-1], cbx});
			dy_s1   <= signed'({cay[CW-1], cay}) - signed'({cby[CW-1], cby});
			sumx_s1 <= {1'b0, a_width} + {1'b0, b_width};
			sumy_s1 <= {1'b0, a_height} + {1'b0, b_height};
		end
	end

	// Twice the distance lies strictly between minus and plus the size sum.
	always_comb begin
		twox = SW'(dx_s1) <<< 1;
		twoy = SW'(dy_s1) <<< 1;
		sx   = signed'(SW'(sumx_s1));
		sy   = signed'(SW'(sumy_s1));
		hit  = (sx + twox > 0) && (sx - twox > 0) && (sy + twoy > 0) && (sy - twoy > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else if (adv.ld_s2) begin
			hit_s2 <= hit;
		end
	end

endmodule

`default_nettype wire

[rtl/box_overlap_pair_event_tracker.sv]
// Top level of the box overlap pair event tracker: handshakes, pair table, event logic.
// Depends on bopt_pkg, bopt_ram, bopt_overlap and the shared assertion macros.
//
// Usage: each input beat on the s_ group carries one candidate pair of boxes; each
// pair yields exactly one output beat on the m_ group with the event code (none,
// enter, stay, exit) and the pair ids ordered low first. The touching flag of each
// ordered pair lives in a one-bit-wide table of ID_COUNT*ID_COUNT entries.
// A pair passes the first stage, the second stage and the output register in turn.
// A new pair is accepted every cycle unless the receiver stalls; the rate is set by
// the single read-modify-write of the table per pair, with the read issued in the
// first stage and the write in the second, and a forwarding path covers back-to-back
// pairs that hit the same entry. After reset the table is cleared one entry per cycle,
// all ID_COUNT*ID_COUNT entries (4096 with the default), while s_tready stays low.
// When the receiver stalls, the output register holds its beat and the two internal
// stages still fill, so up to three pairs are taken before s_tready falls.
// Equal ids, or an id at or above ID_COUNT, give event none and leave the table alone.
`default_nettype none

module box_overlap_pair_event_tracker #(
	parameter int ID_COUNT = bopt_pkg::ID_COUNT_DEF,
	parameter int COORD_BITS = bopt_pkg::COORD_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// id_a, id_b, a_center_x, a_center_y, a_width, a_height, b_center_x,
	// b_center_y, b_width, b_height, a_dead, b_dead, zero fill.
	input  wire logic [bopt_pkg::IN_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// event_res, lower_id, upper_id, zero fill.
	output logic      [bopt_pkg::OUT_W-1:0] m_tdata
);

	import bopt_pkg::*;

	`include "box_overlap_pair_event_tracker_defines.svh"

	localparam int DEPTH = ID_COUNT * ID_COUNT;
	localparam int AW = $clog2(DEPTH);

	localparam int P_IDB = ID_W;
	localparam int P_ACX = 2 * ID_W;
	localparam int P_ACY = P_ACX + CENTER_W;
	localparam int P_AW = P_ACY + CENTER_W;
	localparam int P_AH = P_AW + SIZE_W;
	localparam int P_BCX = P_AH + SIZE_W;
	localparam int P_BCY = P_BCX + CENTER_W;
	localparam int P_BW = P_BCY + CENTER_W;
	localparam int P_BH = P_BW + SIZE_W;
	localparam int P_AD = P_BH + SIZE_W;
	localparam int P_BD = P_AD + 1;

	logic [ID_W-1:0] id_a, id_b, lo, hi;
	logic            ok, alive;
	logic [AW-1:0]   addr;

	logic            clearing_q;
	logic [AW-1:0]   clr_q;

	logic            valid_s1, ok_s1, alive_s1;
	logic [ID_W-1:0] lo_s1, hi_s1;
	logic [AW-1:0]   addr_s1;

	logic            valid_s2, ok_s2, alive_s2, fwd_s2, fwdval_s2;
	logic [ID_W-1:0] lo_s2, hi_s2;
	logic [AW-1:0]   addr_s2;

	logic            out_valid_q;
	logic [OUT_W-1:0] out_q;

	logic            acc, mv_out, fwd_hit, s2_load;
	bopt_adv_t       adv;
	logic            hit_s2, rdata, was, now_v;
	bopt_event_t     ev;
	logic            we, wdata;
	logic [AW-1:0]   waddr;

	assign id_a  = s_tdata[P_IDB-1:0];
	assign id_b  = s_tdata[P_ACX-1:P_IDB];
	assign lo    = (id_a < id_b) ? id_a : id_b;
	assign hi    = (id_a < id_b) ? id_b : id_a;
	assign ok    = (lo != hi) && (32'(hi) < 32'(ID_COUNT));
	assign alive = !s_tdata[P_AD] && !s_tdata[P_BD];
	assign addr  = AW'(AW'(lo) * AW'(ID_COUNT)) + AW'(hi);

	assign mv_out   = valid_s2 && (!out_valid_q || m_tready);
	assign s2_load  = valid_s1 && (!valid_s2 || mv_out);
	assign s_tready = !clearing_q && (!valid_s1 || s2_load);
	assign acc      = s_tvalid && s_tready;
	assign adv      = '{ld_s1: acc, ld_s2: s2_load};

	bopt_overlap #(
		.COORD_BITS(COORD_BITS)
	) u_overlap (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.a_center_x (s_tdata[P_ACY-1:P_ACX]),
		.a_center_y (s_tdata[P_AW-1:P_ACY]),
		.a_width    (s_tdata[P_AH-1:P_AW]),
		.a_height   (s_tdata[P_BCX-1:P_AH]),
		.b_center_x (s_tdata[P_BCY-1:P_BCX]),
		.b_center_y (s_tdata[P_BW-1:P_BCY]),
		.b_width    (s_tdata[P_BH-1:P_BW]),
		.b_height   (s_tdata[P_AD-1:P_BH]),
		.hit_s2     (hit_s2)
	);

	assign was = fwd_s2 ? fwdval_s2 : rdata;

	always_comb begin
		ev    = EV_NONE;
		now_v = 1'b0;
		if (ok_s2) begin
			if (hit_s2) begin
				if (!was) begin
					if (alive_s2) begin
						ev    = EV_ENTER;
						now_v = 1'b1;
					end
				end else if (alive_s2) begin
					ev    = EV_STAY;
					now_v = 1'b1;
				end else begin
					ev = EV_EXIT;
				end
			end else if (was) begin
				ev = EV_EXIT;
			end
		end
	end

	assign we      = clearing_q || (mv_out && ok_s2);
	assign waddr   = clearing_q ? clr_q : addr_s2;
	assign wdata   = clearing_q ? 1'b0 : now_v;
	assign fwd_hit = mv_out && ok_s2 && (addr_s2 == addr_s1);

	bopt_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (s2_load),
		.raddr (addr_s1),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_s2      <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s2_load) begin
				valid_s1 <= 1'b0;
			end
			if (s2_load) begin
				valid_s2 <= 1'b1;
				fwd_s2   <= fwd_hit;
			end else if (mv_out) begin
				valid_s2 <= 1'b0;
			end
			if (mv_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			lo_s1    <= lo;
			hi_s1    <= hi;
			ok_s1    <= ok;
			alive_s1 <= alive;
			addr_s1  <= addr;
		end
		if (s2_load) begin
			lo_s2     <= lo_s1;
			hi_s2     <= hi_s1;
			ok_s2     <= ok_s1;
			alive_s2  <= alive_s1;
			addr_s2   <= addr_s1;
			fwdval_s2 <= now_v;
		end
		if (mv_out) begin
			out_q <= OUT_W'({hi_s2, lo_s2, ev});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	`BOPT_ASSERT(a_clear_blocks_input, clk, arst_n, clearing_q |-> !s_tready)
	`BOPT_ASSERT_NEVER(a_clear_pipe_empty, clk, arst_n, clearing_q && (valid_s1 || valid_s2 || out_valid_q))
	`BOPT_ASSERT(a_same_entry_forward, clk, arst_n, (we && !clearing_q && s2_load && waddr == addr_s1) |=> fwd_s2)
	`BOPT_ASSERT(a_enter_sets_flag, clk, arst_n, (mv_out && ev == EV_ENTER) |-> (we && wdata))
	`BOPT_ASSERT(a_no_table_no_event, clk, arst_n, (mv_out && !ok_s2) |=> (m_tdata[EV_W-1:0] == EV_NONE))

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for box_overlap_pair_event_tracker: drives candidate box pairs,
// predicts the enter, stay and exit events with its own touching-flag table and checks
// each result beat. Depends on bopt_pkg and the RTL of the block.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bopt_pkg::*;

	localparam int PAIR_SLOTS = ID_COUNT_DEF * ID_COUNT_DEF;

	typedef struct {
		logic [ID_W-1:0] id_a;
		logic [ID_W-1:0] id_b;
		logic signed [CENTER_W-1:0] a_cx;
		logic signed [CENTER_W-1:0] a_cy;
		logic [SIZE_W-1:0] a_w;
		logic [SIZE_W-1:0] a_h;
		logic signed [CENTER_W-1:0] b_cx;
		logic signed [CENTER_W-1:0] b_cy;
		logic [SIZE_W-1:0] b_w;
		logic [SIZE_W-1:0] b_h;
		logic a_dead;
		logic b_dead;
	} box_pair_t;

	typedef struct {
		bopt_event_t ev;
		logic [ID_W-1:0] lo_id;
		logic [ID_W-1:0] hi_id;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	bit touching_flags [PAIR_SLOTS];
	contact_t contact_q[$];
	int err_count = 0;
	int pairs_sent = 0;
	int directed_n = 0;
	int event_tally [4] = '{0, 0, 0, 0};
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int hold_cycles = 0;
	int holds_done = 0;

	box_overlap_pair_event_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit axis_hits(logic signed [CENTER_W-1:0] ca, logic signed [CENTER_W-1:0] cb,
			logic [SIZE_W-1:0] sa, logic [SIZE_W-1:0] sb);
		longint delta;
		delta = longint'(ca) - longint'(cb);
		if (delta < 0) begin
			delta = -delta;
		end
		return 2 * delta < longint'(sa) + longint'(sb);
	endfunction

	// Computes the event for one pair and rewrites its touching flag.
	function automatic contact_t predict_contact(box_pair_t p);
		contact_t r;
		int slot;
		bit was, alive, hit, now;
		r.lo_id = (p.id_a < p.id_b) ? p.id_a : p.id_b;
		r.hi_id = (p.id_a < p.id_b) ? p.id_b : p.id_a;
		r.ev = EV_NONE;
		if (r.lo_id != r.hi_id && int'(r.hi_id) < ID_COUNT_DEF) begin
			slot = int'(r.lo_id) * ID_COUNT_DEF + int'(r.hi_id);
			was = touching_flags[slot];
			alive = !p.a_dead && !p.b_dead;
			hit = axis_hits(p.a_cx, p.b_cx, p.a_w, p.b_w) && axis_hits(p.a_cy, p.b_cy, p.a_h, p.b_h);
			now = 1'b0;
			if (hit) begin
				if (!was) begin
					if (alive) begin
						r.ev = EV_ENTER;
						now = 1'b1;
					end
				end else if (alive) begin
					r.ev = EV_STAY;
					now = 1'b1;
				end else begin
					r.ev = EV_EXIT;
				end
			end else if (was) begin
				r.ev = EV_EXIT;
			end
			touching_flags[slot] = now;
		end
		return r;
	endfunction

	function automatic box_pair_t mk_pair(int ia, int ib, int ax, int ay, int aw, int ah,
			int bx, int by, int bw, int bh, bit ad, bit bd);
		box_pair_t p;
		p.id_a = ID_W'(ia);
		p.id_b = ID_W'(ib);
		p.a_cx = CENTER_W'(ax);
		p.a_cy = CENTER_W'(ay);
		p.a_w = SIZE_W'(aw);
		p.a_h = SIZE_W'(ah);
		p.b_cx = CENTER_W'(bx);
		p.b_cy = CENTER_W'(by);
		p.b_w = SIZE_W'(bw);
		p.b_h = SIZE_W'(bh);
		p.a_dead = ad;
		p.b_dead = bd;
		return p;
	endfunction

	// Mostly pairs from a small id pool placed close together, so that flags get set and
	// revisited; the rest is unconstrained noise over the full field ranges.
	function automatic box_pair_t random_pair();
		box_pair_t p;
		int bx, by;
		p.id_a = ($urandom_range(0, 4) == 0) ? ID_W'($urandom_range(0, 63)) : ID_W'($urandom_range(0, 7));
		p.id_b = ($urandom_range(0, 4) == 0) ? ID_W'($urandom_range(0, 63)) : ID_W'($urandom_range(0, 7));
		if ($urandom_range(0, 99) >= 85) begin
			p.a_cx = CENTER_W'($urandom);
			p.a_cy = CENTER_W'($urandom);
			p.a_w = SIZE_W'($urandom);
			p.a_h = SIZE_W'($urandom);
			p.b_cx = CENTER_W'($urandom);
			p.b_cy = CENTER_W'($urandom);
			p.b_w = SIZE_W'($urandom);
			p.b_h = SIZE_W'($urandom);
		end else begin
			bx = int'($urandom_range(0, 60000)) - 30000;
			by = int'($urandom_range(0, 60000)) - 30000;
			p.a_w = SIZE_W'($urandom_range(0, 200));
			p.a_h = SIZE_W'($urandom_range(0, 200));
			p.b_w = SIZE_W'($urandom_range(0, 200));
			p.b_h = SIZE_W'($urandom_range(0, 200));
			p.a_cx = CENTER_W'(bx);
			p.a_cy = CENTER_W'(by);
			p.b_cx = CENTER_W'(bx + int'($urandom_range(0, 300)) - 150);
			p.b_cy = CENTER_W'(by + int'($urandom_range(0, 300)) - 150);
			if ($urandom_range(0, 9) == 0) begin
				p.b_cx = CENTER_W'(bx + (int'(p.a_w) + int'(p.b_w)) / 2);
			end
		end
		p.a_dead = ($urandom_range(0, 9) == 0);
		p.b_dead = ($urandom_range(0, 9) == 0);
		return p;
	endfunction

	task automatic report_mismatch(string what);
		if (err_count < 50) begin
			$display("MISMATCH at %0t ns: %s", $time, what);
		end
		err_count++;
	endtask

	task automatic send_pair(box_pair_t p);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({p.b_dead, p.a_dead, p.b_h, p.b_w, p.b_cy, p.b_cx,
			p.a_h, p.a_w, p.a_cy, p.a_cx, p.id_b, p.id_a});
		do @(posedge clk); while (!s_tready);
		contact_q.push_back(predict_contact(p));
		pairs_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (contact_q.size() != 0);
	endtask

	task automatic check_contact(logic [OUT_W-1:0] beat);
		contact_t want;
		bopt_event_t got_ev;
		got_ev = bopt_event_t'(beat[EV_W-1:0]);
		if (contact_q.size() == 0) begin
			report_mismatch($sformatf("result beat 0x%0h with no pair pending", beat));
			return;
		end
		want = contact_q.pop_front();
		if (got_ev != want.ev) begin
			report_mismatch($sformatf("pair %0d/%0d event %s, predicted %s",
				want.lo_id, want.hi_id, got_ev.name(), want.ev.name()));
		end
		if (beat[EV_W +: ID_W] != want.lo_id) begin
			report_mismatch($sformatf("lower_id %0d, predicted %0d", beat[EV_W +: ID_W], want.lo_id));
		end
		if (beat[EV_W + ID_W +: ID_W] != want.hi_id) begin
			report_mismatch($sformatf("upper_id %0d, predicted %0d",
				beat[EV_W + ID_W +: ID_W], want.hi_id));
		end
		event_tally[want.ev]++;
	endtask

	// Result side: random stalls, long hold-offs on request, one check per accepted beat.
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = 0;
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
				holds_done++;
			end else if (rx_idle_en) begin
				stall = $urandom_range(0, 10);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_contact(m_tdata);
		end
	end

	task automatic test_directed();
		box_pair_t seq [$];
		seq = '{
			mk_pair(1, 2, 0, 0, 10, 10, 3, 3, 10, 10, 0, 0),
			mk_pair(1, 2, 0, 0, 10, 10, -3, -3, 10, 10, 0, 0),
			mk_pair(2, 1, 5, 5, 10, 10, 0, 0, 10, 10, 0, 0),
			mk_pair(1, 2, 0, 0, 10, 10, 500, 0, 10, 10, 0, 0),
			mk_pair(1, 2, 0, 0, 10, 10, 500, 0, 10, 10, 0, 0),
			mk_pair(3, 4, 0, 0, 10, 10, 1, 1, 10, 10, 1, 0),
			mk_pair(3, 4, 0, 0, 10, 10, 1, 1, 10, 10, 0, 0),
			mk_pair(4, 3, 0, 0, 10, 10, 1, 1, 10, 10, 0, 1),
			mk_pair(5, 5, 0, 0, 10, 10, 0, 0, 10, 10, 0, 0),
			mk_pair(0, 63, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0),
			mk_pair(63, 0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0),
			mk_pair(0, 63, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 1, 1),
			mk_pair(6, 7, 0, 0, 10, 10, 10, 0, 10, 10, 0, 0),
			mk_pair(6, 7, 0, 0, 10, 10, 9, 0, 10, 10, 0, 0),
			mk_pair(6, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			mk_pair(8, 9, 7, 7, 0, 4, 7, 7, 1, 4, 0, 0),
			mk_pair(63, 63, -1, -1, 32767, 32767, -1, -1, 32767, 32767, 1, 1),
			mk_pair(9, 8, 0, 0, 4, 4, 0, 100, 4, 4, 0, 0),
			mk_pair(10, 11, 0, 0, 4, 4, 900, 900, 4, 4, 1, 1),
			mk_pair(12, 13, 0, 0, 8, 8, 1, 1, 8, 8, 1, 1),
			mk_pair(13, 12, 0, 0, 8, 8, 1, 1, 8, 8, 0, 0)
		};
		foreach (seq[i]) begin
			send_pair(seq[i]);
		end
		directed_n = seq.size();
		drain_results();
	endtask

	task automatic test_random_traffic(int n);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (n) send_pair(random_pair());
	endtask

	task automatic test_steady_stream(int n);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (n) send_pair(random_pair());
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// The receiver holds off after its next beat while pairs keep coming back to back,
	// so the pipeline fills and the input side has to stall.
	task automatic test_backpressure();
		for (int k = 0; k < 2; k++) begin
			hold_cycles = (k == 0) ? 80 : 150;
			tx_idle_en = 1'b0;
			repeat (40) send_pair(random_pair());
			tx_idle_en = 1'b1;
		end
	endtask

	task automatic test_pause_and_resume();
		repeat (10) begin
			repeat (25) send_pair(random_pair());
			drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_traffic(1050);
		test_steady_stream(300);
		test_backpressure();
		test_pause_and_resume();
		drain_results();
		repeat (8) @(posedge clk);
		if (contact_q.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", contact_q.size()));
		end
		$display("Covered %0d pairs (%0d directed) with %0d receiver hold-offs.",
			pairs_sent, directed_n, holds_done);
		$display("Events seen: none %0d, enter %0d, stay %0d, exit %0d.",
			event_tally[EV_NONE], event_tally[EV_ENTER], event_tally[EV_STAY], event_tally[EV_EXIT]);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout: the run did not finish in time.");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/bopt_pkg.sv
rtl/bopt_ram.sv
rtl/bopt_overlap.sv
rtl/box_overlap_pair_event_tracker.sv
dv/tb_top.sv
